@@ design/act_pkg.sv @@
`default_nettype none
package act_pkg;

  localparam int unsigned CmdW  = 2;
  localparam int unsigned AgeW  = 5;
  localparam int unsigned RegW  = 4;
  localparam int unsigned VolW  = 32;
  localparam int unsigned WrkW  = 3;
  localparam int unsigned SeedW = 48;
  localparam int unsigned ThrW  = 5;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 48;
  localparam int unsigned MortW = 16;

  localparam logic [AgeW-1:0] MaxObjAge   = 5'd15;
  localparam logic [ThrW-1:0] RingReset   = 5'd16;

  typedef enum logic [CmdW-1:0] {
    CMD_SAMPLE    = 2'd0,
    CMD_CENSUS    = 2'd1,
    CMD_RST_GLOBAL = 2'd2,
    CMD_RST_LOCAL = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ADAPTIVE  = 3'd0,
    CFG_IGNORE    = 3'd1,
    CFG_MIN_AGE   = 3'd2,
    CFG_MAX_AGE   = 3'd3,
    CFG_FIXED     = 3'd4,
    CFG_POP_FLOOR = 3'd5,
    CFG_MORT      = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SAMPLE_WR,
    ST_CENSUS_RD,
    ST_CENSUS_ACC,
    ST_THR_INIT,
    ST_THR_CUR,
    ST_THR_PREV,
    ST_THR_MUL,
    ST_THR_CMP,
    ST_OUT
  } state_e;

endpackage
`default_nettype wire

@@ design/act_in_if.sv @@
`default_nettype none
interface act_in_if;
  import act_pkg::*;
  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  command;
  logic [AgeW-1:0]  object_age;
  logic [RegW-1:0]  rgn_age;
  logic [VolW-1:0]  volume;
  logic [WrkW-1:0]  worker;
  logic [SeedW-1:0] seed_count;

  modport source (output valid, command, object_age, rgn_age, volume, worker,
                  seed_count, input ready);
  modport sink (input valid, command, object_age, rgn_age, volume, worker,
                seed_count, output ready);
endinterface

interface act_out_if;
  import act_pkg::*;
  logic            valid;
  logic            ready;
  logic [ThrW-1:0] threshold;
  logic            sample_skipped;

  modport source (output valid, threshold, sample_skipped, input ready);
  modport sink (input valid, threshold, sample_skipped, output ready);
endinterface
`default_nettype wire

@@ design/act_ram.sv @@
`default_nettype none
module act_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ design/age_census_tenuring_threshold.sv @@
// Age census and tenuring threshold unit.
// Items arrive on in_i (valid/ready); every accepted transaction yields exactly one
// transaction on out_o carrying the threshold of the current epoch and a skip flag.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i only while idle,
// a rule for the user that the block itself does not enforce. A sample that is kept
// reads the worker histogram entry, then writes the saturated sum back and presents
// the result. A census walks the worker memory one entry at a time, reading it in
// CENSUS_RD and accumulating and clearing it in CENSUS_ACC, then searches cohorts
// through THR_CUR, THR_PREV, THR_MUL and THR_CMP for each cohort, since the single
// global memory read port is read twice per cohort and the mortality product is
// registered. Reset global clears the epoch valid bits, resets the epoch and then
// answers; reset local sweeps the worker memory (one entry per cycle) and then answers.
// After reset the worker memory is cleared by the same sweep over all its entries,
// during which no item is accepted. Global rows are tracked by per-epoch valid bits,
// so they need no sweep. A new item is accepted while a finished result still waits
// in the output register; if the receiver stalls, the following item waits at its
// last step until the output register frees up.
`default_nettype none
module age_census_tenuring_threshold #(
  parameter int unsigned COHORTS    = 16,
  parameter int unsigned SNAPSHOTS  = 16,
  parameter int unsigned WORKERS    = 8,
  parameter int unsigned COUNT_BITS = 48
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  act_in_if.sink                              in_i,
  act_out_if.source                           out_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [act_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [act_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import act_pkg::*;

  localparam int unsigned CB   = $clog2(COHORTS);
  localparam int unsigned EB   = $clog2(SNAPSHOTS);
  localparam int unsigned WB   = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int unsigned WAW  = WB + CB;
  localparam int unsigned GAW  = EB + CB;
  localparam int unsigned PW   = COUNT_BITS + MortW;

  typedef logic [COUNT_BITS-1:0] cnt_t;

  function automatic cnt_t sat_add(cnt_t a, cnt_t b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
  endfunction

  // configuration
  logic             adaptive_q, ignore_q;
  logic [ThrW-1:0]  min_age_q, max_age_q, fixed_q;
  logic [SeedW-1:0] pop_floor_q;
  logic [MortW-1:0] mort_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adaptive_q  <= 1'b1;
      ignore_q    <= 1'b1;
      min_age_q   <= 5'd1;
      max_age_q   <= 5'd15;
      fixed_q     <= 5'd7;
      pop_floor_q <= '0;
      mort_q      <= 16'd6554;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ADAPTIVE:  adaptive_q  <= cfg_wdata_i[0];
        CFG_IGNORE:    ignore_q    <= cfg_wdata_i[0];
        CFG_MIN_AGE:   min_age_q   <= cfg_wdata_i[ThrW-1:0];
        CFG_MAX_AGE:   max_age_q   <= cfg_wdata_i[ThrW-1:0];
        CFG_FIXED:     fixed_q     <= cfg_wdata_i[ThrW-1:0];
        CFG_POP_FLOOR: pop_floor_q <= cfg_wdata_i[SeedW-1:0];
        CFG_MORT:      mort_q      <= cfg_wdata_i[MortW-1:0];
        default: ;
      endcase
    end
  end

  // state
  state_e state_q, state_d;
  logic [EB-1:0]    epoch_q;
  logic [ThrW-1:0]  ring_q [SNAPSHOTS];
  logic [SNAPSHOTS-1:0] gvalid_q;
  logic             out_valid_q, out_skip_q;
  logic [ThrW-1:0]  out_thr_q;
  logic             pend_q;
  logic             skip_q;
  logic [WB-1:0]    w_q;
  logic [CB-1:0]    c_q;
  logic [WAW-1:0]   clr_q;
  logic [VolW-1:0]  vol_q;
  cnt_t             acc_q, cur_q, prev_q;
  logic [PW-1:0]    prod_q;
  logic [ThrW-1:0]  tt_q, i_q, lower_q, prev_tt_q;

  // memories
  logic             w_we, w_re, g_we, g_re;
  logic [WAW-1:0]   w_waddr, w_raddr;
  cnt_t             w_wdata, w_rdata, g_rdata, g_wdata;
  logic [GAW-1:0]   g_raddr, g_waddr;

  act_ram #(.WIDTH(COUNT_BITS), .DEPTH(2**WAW)) u_worker_ram (
    .clk_i, .we_i(w_we), .waddr_i(w_waddr), .wdata_i(w_wdata),
    .re_i(w_re), .raddr_i(w_raddr), .rdata_o(w_rdata)
  );

  act_ram #(.WIDTH(COUNT_BITS), .DEPTH(2**GAW)) u_global_ram (
    .clk_i, .we_i(g_we), .waddr_i(g_waddr), .wdata_i(g_wdata),
    .re_i(g_re), .raddr_i(g_raddr), .rdata_o(g_rdata)
  );

  // input decode
  logic             in_fire;
  logic [5:0]       age_sum;
  logic [CB-1:0]    in_cohort;
  logic             in_skip, in_wrk_ok;
  logic [63:0]      seed64;
  cnt_t             seed_sat;
  logic [EB-1:0]    epoch_next, prev_e;
  logic             out_free;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign age_sum    = 6'(in_i.object_age) + 6'(in_i.rgn_age);
  assign in_cohort  = (age_sum > 6'(COHORTS - 1)) ? CB'(COHORTS - 1) : CB'(age_sum);
  assign in_skip    = (in_i.object_age > MaxObjAge);
  assign in_wrk_ok  = (32'(in_i.worker) < WORKERS);
  assign seed64     = 64'(in_i.seed_count);
  assign seed_sat   = ((seed64 >> COUNT_BITS) != 64'd0) ? '1 : seed64[COUNT_BITS-1:0];
  assign epoch_next = (epoch_q == EB'(SNAPSHOTS - 1)) ? '0 : epoch_q + 1'b1;
  assign prev_e     = (epoch_q == '0) ? EB'(SNAPSHOTS - 1) : epoch_q - 1'b1;
  assign out_free   = !out_valid_q || out_o.ready;

  // bounds of the threshold search
  logic [5:0]      upper;
  logic [ThrW-1:0] lower;
  always_comb begin
    upper = {1'b0, max_age_q};
    if (ignore_q && prev_tt_q != '0 && (6'(prev_tt_q) + 6'd1) < upper) begin
      upper = 6'(prev_tt_q) + 6'd1;
    end
    if (upper > 6'(COHORTS - 1)) begin
      upper = 6'(COHORTS - 1);
    end
    lower = (min_age_q == '0) ? 5'd1 : min_age_q;
  end

  // mortality test
  cnt_t          g_eff;
  logic          hit;
  logic [PW-1:0] lhs;
  assign g_eff = gvalid_q[prev_e] ? g_rdata : '0;
  assign lhs   = {prev_q - cur_q, 16'h0};
  assign hit   = (64'(prev_q) > 64'(pop_floor_q)) && (prev_q > cur_q) && (lhs > prod_q);

  cnt_t census_sum;
  assign census_sum = sat_add(acc_q, w_rdata);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_i.command)
            CMD_SAMPLE:     state_d = (!in_skip && in_wrk_ok) ? ST_SAMPLE_WR : ST_OUT;
            CMD_CENSUS:     state_d = ST_CENSUS_RD;
            CMD_RST_GLOBAL: state_d = ST_OUT;
            default:        state_d = ST_CLEAR;
          endcase
        end
      end
      ST_CLEAR: begin
        if (clr_q == '1) state_d = pend_q ? ST_OUT : ST_IDLE;
      end
      ST_SAMPLE_WR: if (out_free) state_d = ST_IDLE;
      ST_CENSUS_RD: state_d = ST_CENSUS_ACC;
      ST_CENSUS_ACC: begin
        if (w_q == WB'(WORKERS - 1) && c_q == CB'(COHORTS - 1)) state_d = ST_THR_INIT;
        else state_d = ST_CENSUS_RD;
      end
      ST_THR_INIT: begin
        if (!adaptive_q || max_age_q == min_age_q || upper < 6'(lower)) state_d = ST_OUT;
        else state_d = ST_THR_CUR;
      end
      ST_THR_CUR:  state_d = ST_THR_PREV;
      ST_THR_PREV: state_d = ST_THR_MUL;
      ST_THR_MUL:  state_d = ST_THR_CMP;
      ST_THR_CMP: begin
        if (hit || i_q == lower_q) state_d = ST_OUT;
        else state_d = ST_THR_CUR;
      end
      ST_OUT: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // memory and ring controls
  logic            ring_we;
  logic [ThrW-1:0] ring_wd;
  always_comb begin
    w_re    = 1'b0;
    w_raddr = {w_q, c_q};
    w_we    = 1'b0;
    w_waddr = {w_q, c_q};
    w_wdata = '0;
    g_re    = 1'b0;
    g_raddr = {epoch_q, i_q[CB-1:0]};
    g_we    = 1'b0;
    g_waddr = {epoch_q, c_q};
    g_wdata = census_sum;
    ring_we = 1'b0;
    ring_wd = tt_q;
    unique case (state_q)
      ST_IDLE: begin
        w_re    = in_fire && (in_i.command == CMD_SAMPLE);
        w_raddr = {WB'(in_i.worker), in_cohort};
      end
      ST_CLEAR: begin
        w_we    = 1'b1;
        w_waddr = clr_q;
      end
      ST_SAMPLE_WR: begin
        w_we    = out_free;
        w_wdata = sat_add(w_rdata, cnt_t'(vol_q));
      end
      ST_CENSUS_RD: w_re = 1'b1;
      ST_CENSUS_ACC: begin
        w_we = 1'b1;
        g_we = (w_q == WB'(WORKERS - 1));
      end
      ST_THR_INIT: begin
        ring_we = 1'b1;
        if (!adaptive_q) ring_wd = fixed_q;
        else if (max_age_q == min_age_q) ring_wd = max_age_q;
        else ring_wd = upper[ThrW-1:0];
      end
      ST_THR_CUR: g_re = 1'b1;
      ST_THR_PREV: begin
        g_re    = 1'b1;
        g_raddr = {prev_e, CB'(i_q - 5'd1)};
      end
      ST_THR_CMP: begin
        ring_we = hit || i_q == lower_q;
        ring_wd = hit ? tt_q : i_q;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      epoch_q     <= EB'(SNAPSHOTS - 1);
      gvalid_q    <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      clr_q       <= '0;
      w_q         <= '0;
      c_q         <= '0;
      for (int k = 0; k < SNAPSHOTS; k++) ring_q[k] <= RingReset;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_o.ready) out_valid_q <= 1'b0;
      if ((state_q == ST_OUT || state_q == ST_SAMPLE_WR) && out_free) begin
        out_valid_q <= 1'b1;
      end
      if (ring_we) ring_q[epoch_q] <= ring_wd;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (in_fire) begin
        w_q <= '0;
        c_q <= '0;
        pend_q <= 1'b1;
        if (in_i.command == CMD_SAMPLE) begin
          w_q <= WB'(in_i.worker);
          c_q <= in_cohort;
        end
        if (in_i.command == CMD_CENSUS) begin
          epoch_q <= epoch_next;
        end
        if (in_i.command == CMD_RST_GLOBAL) begin
          gvalid_q <= '0;
          epoch_q  <= EB'(SNAPSHOTS - 1);
        end
      end
      if (state_q == ST_CENSUS_ACC) begin
        if (w_q == WB'(WORKERS - 1)) begin
          w_q <= '0;
          c_q <= c_q + 1'b1;
          if (c_q == CB'(COHORTS - 1)) gvalid_q[epoch_q] <= 1'b1;
        end else begin
          w_q <= w_q + 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      vol_q     <= in_i.volume;
      skip_q    <= (in_i.command == CMD_SAMPLE) && in_skip;
      acc_q     <= seed_sat;
      prev_tt_q <= ring_q[epoch_q];
    end
    if (state_q == ST_CENSUS_ACC) begin
      acc_q <= (w_q == WB'(WORKERS - 1)) ? '0 : census_sum;
    end
    if (state_q == ST_THR_INIT) begin
      tt_q    <= upper[ThrW-1:0];
      i_q     <= upper[ThrW-1:0];
      lower_q <= lower;
    end
    if (state_q == ST_THR_PREV) cur_q <= g_rdata;
    if (state_q == ST_THR_MUL) begin
      prev_q <= g_eff;
      prod_q <= PW'(g_eff) * PW'(mort_q);
    end
    if (state_q == ST_THR_CMP) begin
      tt_q <= i_q;
      i_q  <= i_q - 5'd1;
    end
    if ((state_q == ST_OUT || state_q == ST_SAMPLE_WR) && out_free) begin
      out_thr_q  <= ring_q[epoch_q];
      out_skip_q <= skip_q && (state_q == ST_OUT);
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.threshold      = out_thr_q;
  assign out_o.sample_skipped = out_skip_q;

endmodule
`default_nettype wire

@@ dv/act_census_scoreboard.sv @@
`default_nettype none
package act_census_scoreboard_pkg;
  import act_pkg::*;

  typedef struct packed {
    logic [ThrW-1:0] threshold;
    logic            sample_skipped;
  } census_result_t;

  class census_scoreboard;
    // Mirror of the block's state.
    logic [4:0]  epoch;
    logic [4:0]  thr_ring[16];
    logic [47:0] global_hist[16][16];
    logic [47:0] worker_hist[8][16];
    // Mirror of the registers.
    logic        adaptive;
    logic        ignore_older;
    logic [4:0]  min_age;
    logic [4:0]  max_age;
    logic [4:0]  fixed_thr;
    logic [47:0] pop_floor;
    logic [15:0] mort_floor;

    census_result_t pending[$];
    int errors;

    function new();
      errors = 0;
      epoch = 15;
      adaptive = 1;
      ignore_older = 1;
      min_age = 1;
      max_age = 15;
      fixed_thr = 7;
      pop_floor = '0;
      mort_floor = 16'd6554;
      for (int e = 0; e < 16; e++) begin
        thr_ring[e] = RingReset;
        for (int c = 0; c < 16; c++) global_hist[e][c] = '0;
      end
      clear_workers();
    endfunction

    function void clear_workers();
      for (int w = 0; w < 8; w++)
        for (int c = 0; c < 16; c++) worker_hist[w][c] = '0;
    endfunction

    function logic [47:0] sat_sum(logic [47:0] a, logic [47:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[48] ? {48{1'b1}} : s[47:0];
    endfunction

    function void set_register(cfg_idx_e idx, logic [47:0] value);
      case (idx)
        CFG_ADAPTIVE:  adaptive = value[0];
        CFG_IGNORE:    ignore_older = value[0];
        CFG_MIN_AGE:   min_age = value[4:0];
        CFG_MAX_AGE:   max_age = value[4:0];
        CFG_FIXED:     fixed_thr = value[4:0];
        CFG_POP_FLOOR: pop_floor = value;
        CFG_MORT:      mort_floor = value[15:0];
        default: ;
      endcase
    endfunction

    function bit dies_off(logic [47:0] prev, logic [47:0] cur);
      logic [79:0] lhs, rhs;
      if (prev <= cur) return 0;
      lhs = {32'd0, prev - cur} << 16;
      rhs = {32'd0, prev} * {64'd0, mort_floor};
      return lhs > rhs;
    endfunction

    function logic [4:0] tenuring_age();
      int cur_e, prev_e, upper, lower, tt;
      cur_e = epoch;
      prev_e = (cur_e > 0) ? cur_e - 1 : 15;
      upper = max_age;
      lower = (min_age < 1) ? 1 : min_age;
      if (max_age == min_age) return max_age;
      if (ignore_older && thr_ring[prev_e] > 0 && thr_ring[prev_e] + 1 < upper)
        upper = thr_ring[prev_e] + 1;
      if (upper > 15) upper = 15;
      tt = upper;
      for (int i = upper; i >= lower && i >= 1; i--) begin
        if (global_hist[prev_e][i-1] > pop_floor &&
            dies_off(global_hist[prev_e][i-1], global_hist[cur_e][i]))
          return tt;
        tt = i;
      end
      return tt;
    endfunction

    function void note_item(cmd_e cmd, logic [4:0] obj_age, logic [3:0] reg_age,
                            logic [31:0] volume, logic [2:0] worker,
                            logic [47:0] seed);
      census_result_t r;
      int age;
      r.sample_skipped = 0;
      case (cmd)
        CMD_SAMPLE: begin
          if (obj_age > MaxObjAge) begin
            r.sample_skipped = 1;
          end else begin
            age = obj_age + reg_age;
            if (age > 15) age = 15;
            worker_hist[worker][age] = sat_sum(worker_hist[worker][age], {16'd0, volume});
          end
        end
        CMD_CENSUS: begin
          epoch = (epoch >= 15) ? 0 : epoch + 1;
          for (int c = 0; c < 16; c++) global_hist[epoch][c] = '0;
          global_hist[epoch][0] = seed;
          for (int w = 0; w < 8; w++)
            for (int c = 0; c < 16; c++)
              global_hist[epoch][c] = sat_sum(global_hist[epoch][c], worker_hist[w][c]);
          clear_workers();
          thr_ring[epoch] = adaptive ? tenuring_age() : fixed_thr;
        end
        CMD_RST_GLOBAL: begin
          for (int e = 0; e < 16; e++)
            for (int c = 0; c < 16; c++) global_hist[e][c] = '0;
          epoch = 15;
        end
        default: clear_workers();
      endcase
      r.threshold = thr_ring[epoch];
      pending.push_back(r);
    endfunction

    function void check_result(logic [4:0] thr, logic skipped);
      census_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result thr=%0d skip=%0d", $time, thr, skipped);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (exp_r.threshold !== thr) begin
        $display("%0t: threshold expected %0d actual %0d", $time, exp_r.threshold, thr);
        errors++;
      end
      if (exp_r.sample_skipped !== skipped) begin
        $display("%0t: sample_skipped expected %0d actual %0d", $time,
                 exp_r.sample_skipped, skipped);
        errors++;
      end
    endfunction
  endclass
endpackage
`default_nettype wire

@@ dv/age_census_tenuring_threshold_tb.sv @@
`default_nettype none
module age_census_tenuring_threshold_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import act_pkg::*;
  import act_census_scoreboard_pkg::*;

  localparam int CycleLimit = 2000000;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  bit hold_off = 0;
  int cycles = 0;

  act_in_if  in_ch();
  act_out_if out_ch();

  census_scoreboard census;

  age_census_tenuring_threshold dut (
    .clk_i, .rst_ni, .in_i(in_ch.sink), .out_o(out_ch.source),
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.command = '0;
    in_ch.object_age = '0;
    in_ch.rgn_age = '0;
    in_ch.volume = '0;
    in_ch.worker = '0;
    in_ch.seed_count = '0;
    out_ch.ready = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Results are checked at the edge where the transaction completes.
  always @(posedge clk_i)
    if (rst_ni && out_ch.valid && out_ch.ready)
      census.check_result(out_ch.threshold, out_ch.sample_skipped);

  // Receiver with random stalls, or a long hold-off on request.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_ch.ready <= 0;
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end
      gap = ($urandom_range(9) == 0) ? $urandom_range(30) : $urandom_range(2);
      if ($urandom_range(3) == 0) gap = 0;
      out_ch.ready <= (gap == 0);
      if (gap > 0) begin
        repeat (gap - 1) @(posedge clk_i);
      end
    end
  end

  function automatic logic [47:0] rand48();
    logic [47:0] v;
    v = 48'({$urandom, $urandom});
    case ($urandom_range(5))
      0: v = '0;
      1: v = {48{1'b1}};
      2: v = v >> $urandom_range(47);
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_item(cmd_e cmd, logic [4:0] oa, logic [3:0] ra, logic [31:0] vol,
                           logic [2:0] wk, logic [47:0] seed, bit gaps);
    int gap;
    if (gaps) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(25) : $urandom_range(1);
      repeat (gap) begin
        in_ch.valid <= 0;
        @(posedge clk_i);
      end
    end
    in_ch.valid <= 1;
    in_ch.command <= cmd;
    in_ch.object_age <= oa;
    in_ch.rgn_age <= ra;
    in_ch.volume <= vol;
    in_ch.worker <= wk;
    in_ch.seed_count <= seed;
    do @(posedge clk_i); while (!in_ch.ready);
    census.note_item(cmd, oa, ra, vol, wk, seed);
  endtask

  task automatic send_random(bit gaps);
    int pick;
    logic [31:0] vol;
    pick = $urandom_range(99);
    vol = $urandom;
    if ($urandom_range(4) == 0) vol = vol >> $urandom_range(31);
    if ($urandom_range(19) == 0) vol = '1;
    if (pick < 75)
      send_item(CMD_SAMPLE, ($urandom_range(9) == 0) ? 5'($urandom_range(16, 31))
                : 5'($urandom_range(15)), 4'($urandom), vol, 3'($urandom), rand48(), gaps);
    else if (pick < 93)
      send_item(CMD_CENSUS, 5'($urandom), 4'($urandom), $urandom, 3'($urandom), rand48(),
                gaps);
    else if (pick < 97)
      send_item(CMD_RST_LOCAL, 5'($urandom), 4'($urandom), $urandom, 3'($urandom),
                rand48(), gaps);
    else
      send_item(CMD_RST_GLOBAL, 5'($urandom), 4'($urandom), $urandom, 3'($urandom),
                rand48(), gaps);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (census.pending.size() != 0) @(posedge clk_i);
    repeat (1100) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [47:0] value);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 0;
    census.set_register(idx, value);
    @(posedge clk_i);
  endtask

  task automatic random_config(int kind);
    int lo, hi;
    write_reg(CFG_ADAPTIVE, (kind == 0) ? 48'd0 : 48'($urandom_range(9) != 0));
    write_reg(CFG_IGNORE, 48'($urandom_range(1)));
    lo = (kind == 1) ? 1 : $urandom_range(1, 16);
    hi = (kind == 1) ? 16 : $urandom_range(1, 16);
    if (kind == 2) hi = lo;
    write_reg(CFG_MIN_AGE, 48'(lo));
    write_reg(CFG_MAX_AGE, 48'(hi));
    write_reg(CFG_FIXED, 48'((kind == 1) ? 16 : $urandom_range(16)));
    write_reg(CFG_POP_FLOOR, ($urandom_range(2) == 0) ? rand48() : 48'($urandom_range(1000)));
    write_reg(CFG_MORT, (kind == 1) ? 48'hFFFF : (kind == 3) ? 48'd0 : 48'($urandom));
  endtask

  initial begin
    census = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: extremes, every command, skipped samples, saturation.
    send_item(CMD_CENSUS, 0, 0, 0, 0, 48'd0, 0);
    send_item(CMD_SAMPLE, 5'd15, 4'd15, 32'hFFFF_FFFF, 3'd7, '1, 0);
    send_item(CMD_SAMPLE, 5'd16, 4'd0, 32'd5, 3'd0, '0, 0);
    send_item(CMD_SAMPLE, 5'd31, 4'd15, 32'd5, 3'd3, '0, 0);
    send_item(CMD_SAMPLE, 5'd0, 4'd0, 32'd1000, 3'd0, '0, 0);
    send_item(CMD_SAMPLE, 5'd3, 4'd1, 32'd900, 3'd1, '0, 0);
    send_item(CMD_CENSUS, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFF, 0);
    send_item(CMD_SAMPLE, 5'd1, 4'd0, 32'd10, 3'd2, '0, 0);
    send_item(CMD_CENSUS, 0, 0, 0, 0, 48'd100, 0);
    for (int i = 0; i < 4; i++) send_item(CMD_SAMPLE, 5'd15, 4'd0, '1, 3'd4, '0, 0);
    send_item(CMD_CENSUS, 0, 0, 0, 0, 48'd1, 0);
    send_item(CMD_RST_LOCAL, '1, '1, '1, '1, '1, 0);
    send_item(CMD_RST_GLOBAL, '1, '1, '1, '1, '1, 0);
    send_item(CMD_CENSUS, 0, 0, 0, 0, 48'd7, 0);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      random_config(phase % 4);
      if (phase == 2) begin
        hold_off = 1;
        repeat (60) send_random(0);
        drain();
      end
      for (int i = 0; i < 85; i++) send_random(1);
      drain();
    end
    random_config(1);
    write_reg(CFG_ADAPTIVE, 48'd1);
    for (int i = 0; i < 30; i++) send_random(1);
    drain();

    if (census.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule
`default_nettype wire
